@@ hw/rtl/bfx_pkg.sv @@
// Package for the tape-machine to x86-64 code emitter.
// Holds operation codes, status codes, sizes and the item structs.
// No dependencies.
`default_nettype none
package bfx_pkg;

  localparam int unsigned CodeBytesDefault = 65536;
  localparam int unsigned LoopDepthDefault = 256;

  typedef enum logic [3:0] {
    OP_START  = 4'd0,
    OP_LEFT1  = 4'd1,
    OP_RIGHT1 = 4'd2,
    OP_LEFTN  = 4'd3,
    OP_RIGHTN = 4'd4,
    OP_ZERO   = 4'd5,
    OP_INC    = 4'd6,
    OP_DEC    = 4'd7,
    OP_ADDN   = 4'd8,
    OP_SUBN   = 4'd9,
    OP_OPEN   = 4'd10,
    OP_CLOSE  = 4'd11,
    OP_PRINT  = 4'd12,
    OP_INPUT  = 4'd13,
    OP_FINISH = 4'd14,
    OP_BAD    = 4'd15
  } op_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_UNKNOWN   = 3'd1,
    ST_STACKFULL = 3'd2,
    ST_UNMATCHED = 3'd3,
    ST_BUFFULL   = 3'd4
  } status_t;

  localparam logic [1:0] REG_TAPE = 2'd0;
  localparam logic [1:0] REG_OUT  = 2'd1;
  localparam logic [1:0] REG_PUTC = 2'd2;
  localparam logic [1:0] REG_GETC = 2'd3;

  typedef struct packed {
    logic [3:0]  func;
    logic [31:0] operand;
  } in_item_t;

  typedef struct packed {
    logic        byte_valid;
    logic [15:0] byte_address;
    logic [7:0]  code_byte;
    logic        is_patch;
    logic [2:0]  status;
    logic        last;
  } out_item_t;

  // Classified job handed from the front to the back.
  typedef struct packed {
    op_t         op;
    logic [31:0] operand;
    logic [2:0]  status;     // non-ok: emit a single error result
    logic [31:0] base;       // first code position
    logic [31:0] slot;       // jz displacement position for close
    logic [5:0]  count;      // number of code bytes
  } job_t;

  // Byte i of operation op.
  function automatic logic [7:0] op_byte(input op_t op, input logic [5:0] i,
                                         input logic [63:0] rega,
                                         input logic [63:0] regb,
                                         input logic [31:0] opnd,
                                         input logic [31:0] disp);
    logic [7:0] b;
    b = 8'h00;
    case (op)
      OP_START: begin
        if (i == 6'd0) b = 8'h53;
        else if (i == 6'd1) b = 8'h51;
        else if (i == 6'd2) b = 8'h52;
        else if (i == 6'd3 || i == 6'd13 || i == 6'd23) b = 8'h48;
        else if (i == 6'd4) b = 8'hB9;
        else if (i == 6'd14) b = 8'hBB;
        else if (i == 6'd24) b = 8'hBA;
        else if (i >= 6'd5 && i <= 6'd12) b = rega[8*(i-6'd5) +: 8];
        else b = 8'h00;
      end
      OP_LEFT1:  b = (i == 6'd0) ? 8'h48 : (i == 6'd1) ? 8'hFF : 8'hCA;
      OP_RIGHT1: b = (i == 6'd0) ? 8'h48 : (i == 6'd1) ? 8'hFF : 8'hC2;
      OP_LEFTN, OP_RIGHTN: begin
        if (i == 6'd0) b = 8'h48;
        else if (i == 6'd1) b = 8'h81;
        else if (i == 6'd2) b = (op == OP_LEFTN) ? 8'hEA : 8'hC2;
        else b = opnd[8*(i-6'd3) +: 8];
      end
      OP_ZERO: b = (i == 6'd0) ? 8'hC6 : (i == 6'd1) ? 8'h04 :
                   (i == 6'd2) ? 8'h11 : 8'h00;
      OP_INC: b = (i == 6'd0) ? 8'hFE : (i == 6'd1) ? 8'h04 : 8'h11;
      OP_DEC: b = (i == 6'd0) ? 8'hFE : (i == 6'd1) ? 8'h0C : 8'h11;
      OP_ADDN, OP_SUBN: begin
        if (i == 6'd0) b = 8'h80;
        else if (i == 6'd1) b = (op == OP_ADDN) ? 8'h04 : 8'h2C;
        else if (i == 6'd2) b = 8'h11;
        else b = opnd[7:0];
      end
      OP_OPEN, OP_CLOSE: begin
        if (i == 6'd0) b = 8'h80;
        else if (i == 6'd1) b = 8'h3C;
        else if (i == 6'd2) b = 8'h11;
        else if (i == 6'd3) b = 8'h00;
        else if (i == 6'd4) b = 8'h0F;
        else if (i == 6'd5) b = (op == OP_OPEN) ? 8'h84 : 8'h85;
        else b = (op == OP_OPEN) ? 8'h00 : disp[8*(i-6'd6) +: 8];
      end
      OP_PRINT: begin
        if (i == 6'd0) b = 8'h52;
        else if (i == 6'd1) b = 8'h51;
        else if (i == 6'd2) b = 8'h40;
        else if (i == 6'd3) b = 8'h8A;
        else if (i == 6'd4) b = 8'h3C;
        else if (i == 6'd5) b = 8'h11;
        else if (i == 6'd6 || i == 6'd16) b = 8'h48;
        else if (i == 6'd7) b = 8'hBE;
        else if (i == 6'd17) b = 8'hBB;
        else if (i >= 6'd8 && i <= 6'd15) b = rega[8*(i-6'd8) +: 8];
        else if (i >= 6'd18 && i <= 6'd25) b = regb[8*(i-6'd18) +: 8];
        else if (i == 6'd26) b = 8'hFF;
        else if (i == 6'd27) b = 8'hD3;
        else if (i == 6'd28) b = 8'h59;
        else b = 8'h5A;
      end
      OP_INPUT: begin
        if (i == 6'd0) b = 8'h52;
        else if (i == 6'd1) b = 8'h51;
        else if (i == 6'd2) b = 8'h48;
        else if (i == 6'd3) b = 8'hBB;
        else if (i >= 6'd4 && i <= 6'd11) b = rega[8*(i-6'd4) +: 8];
        else if (i == 6'd12) b = 8'hFF;
        else if (i == 6'd13) b = 8'hD3;
        else if (i == 6'd14) b = 8'h59;
        else if (i == 6'd15) b = 8'h5A;
        else if (i == 6'd16) b = 8'h88;
        else if (i == 6'd17) b = 8'h04;
        else b = 8'h11;
      end
      OP_FINISH: b = (i == 6'd0) ? 8'h5A : (i == 6'd1) ? 8'h59 :
                     (i == 6'd2) ? 8'h5B : 8'hC3;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [5:0] op_len(input op_t op);
    logic [5:0] n;
    case (op)
      OP_START:  n = 6'd33;
      OP_LEFT1, OP_RIGHT1, OP_INC, OP_DEC: n = 6'd3;
      OP_LEFTN, OP_RIGHTN: n = 6'd7;
      OP_ZERO, OP_ADDN, OP_SUBN, OP_FINISH: n = 6'd4;
      OP_OPEN, OP_CLOSE: n = 6'd10;
      OP_PRINT:  n = 6'd30;
      OP_INPUT:  n = 6'd19;
      default:   n = 6'd0;
    endcase
    return n;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/bfx_if.sv @@
// Valid/ready channel interface for the code emitter.
// Payload type is a parameter; depends on nothing else.
`default_nettype none
interface bfx_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/bfx_front.sv @@
// Front end: accepts operations, checks loops and buffer space, keeps the loop stack.
// Depends on bfx_pkg.
`default_nettype none
module bfx_front #(
  parameter int unsigned CODE_BYTES = bfx_pkg::CodeBytesDefault,
  parameter int unsigned LOOP_DEPTH = bfx_pkg::LoopDepthDefault
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire bfx_pkg::in_item_t in_item,
  output logic                 job_valid,
  input  wire logic            job_ready,
  output bfx_pkg::job_t        job
);
  import bfx_pkg::*;

  localparam int unsigned DW = $clog2(LOOP_DEPTH + 1);
  localparam int unsigned AW = $clog2(LOOP_DEPTH);
  localparam int unsigned PW = $clog2(CODE_BYTES + 1);

  logic [31:0]   stack_mem [LOOP_DEPTH];
  logic [PW-1:0] write_position;
  logic [DW-1:0] loop_depth;

  // Close needs the top entry: register the read alongside the held item.
  logic          rd_pending;
  in_item_t      held;
  logic [31:0]   top;

  logic          out_full;
  job_t          job_reg;
  job_t          job_next;
  logic          decide;
  op_t           op;
  logic [5:0]    len;
  logic [PW:0]   end_pos;
  logic          push;
  logic          pop;
  logic [DW-1:0] depth_next;

  assign op       = op_t'(held.func);
  assign len      = op_len(op);
  assign end_pos  = {1'b0, write_position} + (PW+1)'(len);
  assign decide   = rd_pending && (!out_full || job_ready);
  assign in_ready = !rd_pending || decide;
  assign job_valid = out_full;
  assign job       = job_reg;

  always_comb begin
    job_next = '0;
    job_next.op      = op;
    job_next.operand = held.operand;
    job_next.base    = 32'(write_position);
    job_next.slot    = top;
    job_next.count   = len;
    job_next.status  = ST_OK;
    if (op == OP_BAD) job_next.status = ST_UNKNOWN;
    else if (op == OP_OPEN && loop_depth == DW'(LOOP_DEPTH)) job_next.status = ST_STACKFULL;
    else if (op == OP_CLOSE && loop_depth == '0) job_next.status = ST_UNMATCHED;
    else if (end_pos > (PW+1)'(CODE_BYTES)) job_next.status = ST_BUFFULL;
  end

  assign push = decide && job_next.status == ST_OK && op == OP_OPEN;
  assign pop  = decide && job_next.status == ST_OK && op == OP_CLOSE;
  assign depth_next = push ? loop_depth + DW'(1) :
                      pop  ? loop_depth - DW'(1) : loop_depth;

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held <= in_item;
      // An open decided at this edge pushes the entry the new item sees on top: forward it.
      if (push) top <= 32'(write_position) + 32'd6;
      else top <= stack_mem[AW'(depth_next - DW'(1))];
    end
    if (push)
      stack_mem[AW'(loop_depth)] <= 32'(write_position) + 32'd6;
    if (decide) job_reg <= job_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pending     <= 1'b0;
      out_full       <= 1'b0;
      write_position <= '0;
      loop_depth     <= '0;
    end else begin
      if (job_ready) out_full <= 1'b0;
      if (decide) begin
        out_full <= 1'b1;
        if (job_next.status == ST_OK) begin
          write_position <= end_pos[PW-1:0];
          if (op == OP_OPEN) loop_depth <= loop_depth + DW'(1);
          if (op == OP_CLOSE) loop_depth <= loop_depth - DW'(1);
        end
      end
      if (in_valid && in_ready) rd_pending <= 1'b1;
      else if (decide) rd_pending <= 1'b0;
    end
  end
endmodule
`default_nettype wire

@@ hw/rtl/bfx_queue.sv @@
// Short job queue between front and back.
// Depends on bfx_pkg.
`default_nettype none
module bfx_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          wr_valid,
  output logic               wr_ready,
  input  wire bfx_pkg::job_t wr_job,
  output logic               rd_valid,
  input  wire logic          rd_ready,
  output bfx_pkg::job_t      rd_job
);
  import bfx_pkg::*;

  job_t       slots [4];
  logic [1:0] wp;
  logic [1:0] rp;
  logic [2:0] fill;

  assign wr_ready = fill != 3'd4;
  assign rd_valid = fill != 3'd0;
  assign rd_job   = slots[rp];

  always_ff @(posedge clk) begin
    if (wr_valid && wr_ready) slots[wp] <= wr_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      fill <= '0;
    end else begin
      if (wr_valid && wr_ready) wp <= wp + 2'd1;
      if (rd_valid && rd_ready) rp <= rp + 2'd1;
      fill <= fill + 3'(wr_valid && wr_ready) - 3'(rd_valid && rd_ready);
    end
  end
endmodule
`default_nettype wire

@@ hw/rtl/bfx_back.sv @@
// Back end: sequences a job into addressed result bytes, one per cycle while the result channel takes them.
// Depends on bfx_pkg.
`default_nettype none
module bfx_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          job_valid,
  output logic               job_ready,
  input  wire bfx_pkg::job_t job,
  input  wire logic [63:0]   tape_base,
  input  wire logic [63:0]   out_stream_handle,
  input  wire logic [63:0]   putc_entry,
  input  wire logic [63:0]   getchar_entry,
  output logic               res_valid,
  input  wire logic          res_ready,
  output bfx_pkg::out_item_t res
);
  import bfx_pkg::*;

  logic [5:0]  idx;
  logic        err;
  logic        patching;
  logic        lst;
  logic [31:0] disp;
  logic [31:0] patch;
  logic [63:0] rega;
  logic [63:0] regb;
  logic [1:0]  pidx;
  out_item_t   cur;
  logic        adv;

  assign err   = job.status != ST_OK;
  assign disp  = job.slot - job.base - 32'd6;
  assign patch = job.base + 32'd6 - job.slot;
  assign pidx  = idx[1:0];
  assign adv   = job_valid && (!res_valid || res_ready);

  always_comb begin
    rega = tape_base;
    regb = putc_entry;
    if (job.op == OP_PRINT) rega = out_stream_handle;
    else if (job.op == OP_INPUT) rega = getchar_entry;
  end

  always_comb begin
    cur = '0;
    lst = 1'b0;
    if (err) begin
      cur.status = job.status;
      cur.last   = 1'b1;
      lst        = 1'b1;
    end else if (patching) begin
      cur.byte_valid   = 1'b1;
      cur.byte_address = 16'(job.slot + 32'(pidx));
      cur.code_byte    = patch[8*pidx +: 8];
      cur.is_patch     = 1'b1;
      lst              = pidx == 2'd3;
      cur.last         = lst;
    end else begin
      cur.byte_valid   = 1'b1;
      cur.byte_address = 16'(job.base + 32'(idx));
      cur.code_byte    = op_byte(job.op, idx, rega, regb, job.operand, disp);
      cur.last = (idx == job.count - 6'd1) && job.op != OP_CLOSE;
      lst      = cur.last;
    end
  end

  // Pop the job when its final byte is staged.
  assign job_ready = adv && lst;

  always_ff @(posedge clk) begin
    if (adv) res <= cur;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      idx       <= '0;
      patching  <= 1'b0;
    end else begin
      if (res_ready) res_valid <= 1'b0;
      if (adv) begin
        res_valid <= 1'b1;
        if (lst) begin
          idx <= '0;
          patching <= 1'b0;
        end else if (!patching && job.op == OP_CLOSE && idx == job.count - 6'd1) begin
          idx <= '0;
          patching <= 1'b1;
        end else begin
          idx <= idx + 6'd1;
        end
      end
    end
  end
endmodule
`default_nettype wire

@@ hw/rtl/brainfuck_x86_64_code_emitter.sv @@
// Tape-machine to x86-64 code emitter, top level.
// Each accepted operation yields one addressed code byte per transfer on the
// result channel: 3 to 33 bytes (close adds four jz patch bytes), or one
// status result on error. The back end emits one byte per cycle while the
// result channel takes them; the front end classifies the next item after
// the registered loop stack read and queues it, so the result stream runs
// without gaps. The first result of an item on an idle block passes the held
// item, job, queue and result registers. The loop stack needs no clearing
// pass: only entries pushed by an open are ever used.
// Depends on bfx_pkg, bfx_if, bfx_front, bfx_queue, bfx_back.
`default_nettype none
module brainfuck_x86_64_code_emitter #(
  parameter int unsigned CODE_BYTES = bfx_pkg::CodeBytesDefault,
  parameter int unsigned LOOP_DEPTH = bfx_pkg::LoopDepthDefault
) (
  input wire logic        clk,
  input wire logic        rst,
  bfx_if.sink             in_ch,
  bfx_if.source           out_ch,
  input wire logic        cfg_we,
  input wire logic [1:0]  cfg_index,
  input wire logic [63:0] cfg_data
);
  import bfx_pkg::*;

  logic [63:0] tape_base;
  logic [63:0] out_stream_handle;
  logic [63:0] putc_entry;
  logic [63:0] getchar_entry;

  job_t fj, qj;
  logic fv, fr, qv, qr;

  // Hold configuration registers; the user must write them only while idle, the block itself does not enforce it.
  always_ff @(posedge clk) begin
    if (rst) begin
      tape_base         <= '0;
      out_stream_handle <= '0;
      putc_entry        <= '0;
      getchar_entry     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TAPE: tape_base         <= cfg_data;
        REG_OUT:  out_stream_handle <= cfg_data;
        REG_PUTC: putc_entry        <= cfg_data;
        REG_GETC: getchar_entry     <= cfg_data;
        default: ;
      endcase
    end
  end

  bfx_front #(.CODE_BYTES(CODE_BYTES), .LOOP_DEPTH(LOOP_DEPTH)) u_front (
    .clk, .rst,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_item(in_ch.payload),
    .job_valid(fv), .job_ready(fr), .job(fj)
  );

  bfx_queue u_queue (
    .clk, .rst,
    .wr_valid(fv), .wr_ready(fr), .wr_job(fj),
    .rd_valid(qv), .rd_ready(qr), .rd_job(qj)
  );

  bfx_back u_back (
    .clk, .rst,
    .job_valid(qv), .job_ready(qr), .job(qj),
    .tape_base, .out_stream_handle, .putc_entry, .getchar_entry,
    .res_valid(out_ch.valid), .res_ready(out_ch.ready), .res(out_ch.payload)
  );
endmodule
`default_nettype wire

@@ sim/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking bench for the tape-machine to x86-64 code emitter.
// Predicts every code byte, patch and status from its own model of the block.
// Depends on bfx_pkg, bfx_if and brainfuck_x86_64_code_emitter.
`default_nettype none
module testbench;
  import bfx_pkg::*;

  localparam int unsigned CODE_LIMIT = 65536;
  localparam int unsigned STACK_LIMIT = 256;
  localparam int unsigned CYCLE_LIMIT = 2000000;
  localparam int unsigned DRAIN_CYCLES = 60;

  // Emitter model with its own copy of the registers, stack and write position,
  // holding the code bytes still owed by the block.
  class emitter_scoreboard;
    logic [63:0] regs [4];
    logic [31:0] wpos;
    logic [31:0] slots [STACK_LIMIT];
    int unsigned depth;
    out_item_t owed [$];
    int unsigned errors;

    function new();
      foreach (regs[i]) regs[i] = '0;
      wpos = '0;
      depth = 0;
      errors = 0;
    endfunction

    task report(input string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    function void put_le(ref logic [7:0] b [$], input logic [63:0] v, input int n);
      for (int i = 0; i < n; i++) b = {b, v[8*i +: 8]};
    endfunction

    function void put_mov(ref logic [7:0] b [$], input logic [2:0] r, input logic [63:0] v);
      b = {b, 8'h48, 8'hB8 | {5'd0, r}};
      put_le(b, v, 8);
    endfunction

    function void owe_status(input status_t st);
      out_item_t e;
      e = '0;
      e.status = st;
      e.last = 1'b1;
      owed = {owed, e};
    endfunction

    // Work out the code bytes for one accepted operation.
    function void note(input in_item_t it);
      logic [7:0] b [$];
      op_t op;
      logic [31:0] slot, jpos, patch;
      out_item_t e;
      op = op_t'(it.func);
      slot = '0;
      patch = '0;
      case (op)
        OP_START: begin
          b = {8'h53, 8'h51, 8'h52};
          put_mov(b, 3'd1, regs[REG_TAPE]);
          put_mov(b, 3'd3, 64'd0);
          put_mov(b, 3'd2, 64'd0);
        end
        OP_LEFT1:  b = {8'h48, 8'hFF, 8'hCA};
        OP_RIGHT1: b = {8'h48, 8'hFF, 8'hC2};
        OP_LEFTN: begin
          b = {8'h48, 8'h81, 8'hEA};
          put_le(b, {32'd0, it.operand}, 4);
        end
        OP_RIGHTN: begin
          b = {8'h48, 8'h81, 8'hC2};
          put_le(b, {32'd0, it.operand}, 4);
        end
        OP_ZERO: b = {8'hC6, 8'h04, 8'h11, 8'h00};
        OP_INC:  b = {8'hFE, 8'h04, 8'h11};
        OP_DEC:  b = {8'hFE, 8'h0C, 8'h11};
        OP_ADDN: b = {8'h80, 8'h04, 8'h11, it.operand[7:0]};
        OP_SUBN: b = {8'h80, 8'h2C, 8'h11, it.operand[7:0]};
        OP_OPEN: begin
          if (depth >= STACK_LIMIT) begin
            owe_status(ST_STACKFULL);
            return;
          end
          b = {8'h80, 8'h3C, 8'h11, 8'h00, 8'h0F, 8'h84, 8'h00, 8'h00, 8'h00, 8'h00};
        end
        OP_CLOSE: begin
          if (depth == 0) begin
            owe_status(ST_UNMATCHED);
            return;
          end
          slot = slots[depth-1];
          jpos = wpos + 32'd4;
          b = {8'h80, 8'h3C, 8'h11, 8'h00, 8'h0F, 8'h85};
          put_le(b, {32'd0, slot - jpos - 32'd2}, 4);
          patch = jpos + 32'd2 - slot;
        end
        OP_PRINT: begin
          b = {8'h52, 8'h51, 8'h40, 8'h8A, 8'h3C, 8'h11};
          put_mov(b, 3'd6, regs[REG_OUT]);
          put_mov(b, 3'd3, regs[REG_PUTC]);
          b = {b, 8'hFF, 8'hD3, 8'h59, 8'h5A};
        end
        OP_INPUT: begin
          b = {8'h52, 8'h51};
          put_mov(b, 3'd3, regs[REG_GETC]);
          b = {b, 8'hFF, 8'hD3, 8'h59, 8'h5A, 8'h88, 8'h04, 8'h11};
        end
        OP_FINISH: b = {8'h5A, 8'h59, 8'h5B, 8'hC3};
        default: begin
          owe_status(ST_UNKNOWN);
          return;
        end
      endcase
      if (wpos + b.size() > CODE_LIMIT) begin
        owe_status(ST_BUFFULL);
        return;
      end
      foreach (b[i]) begin
        e = '0;
        e.byte_valid = 1'b1;
        e.byte_address = 16'(wpos + i);
        e.code_byte = b[i];
        e.last = (op != OP_CLOSE) && (i == b.size() - 1);
        owed = {owed, e};
      end
      if (op == OP_OPEN) begin
        slots[depth] = wpos + 32'd6;
        depth++;
      end
      wpos += b.size();
      if (op == OP_CLOSE) begin
        for (int i = 0; i < 4; i++) begin
          e = '0;
          e.byte_valid = 1'b1;
          e.byte_address = 16'(slot + i);
          e.code_byte = patch[8*i +: 8];
          e.is_patch = 1'b1;
          e.last = (i == 3);
          owed = {owed, e};
        end
        depth--;
      end
    endfunction

    task check(input out_item_t got);
      out_item_t e;
      if (owed.size() == 0) begin
        report($sformatf("unexpected result %p", got));
        return;
      end
      e = owed.pop_front();
      if (got.byte_valid !== e.byte_valid)
        report($sformatf("byte_valid %b, want %b", got.byte_valid, e.byte_valid));
      if (got.byte_address !== e.byte_address)
        report($sformatf("byte_address %h, want %h", got.byte_address, e.byte_address));
      if (got.code_byte !== e.code_byte)
        report($sformatf("code_byte %h at %h, want %h", got.code_byte,
                         e.byte_address, e.code_byte));
      if (got.is_patch !== e.is_patch)
        report($sformatf("is_patch %b, want %b", got.is_patch, e.is_patch));
      if (got.status !== e.status)
        report($sformatf("status %0d, want %0d", got.status, e.status));
      if (got.last !== e.last)
        report($sformatf("last %b, want %b", got.last, e.last));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;
  bit idling = 1'b1;
  int unsigned cycles = 0;
  emitter_scoreboard sb = new();

  bfx_if #(.payload_t(in_item_t)) op_ch ();
  bfx_if #(.payload_t(out_item_t)) code_ch ();

  brainfuck_x86_64_code_emitter i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (op_ch),
    .out_ch    (code_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    op_ch.valid = 1'b0;
    op_ch.payload = '0;
    code_ch.ready = 1'b0;
  end

  // Stop a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver: stall in bursts while idling is allowed, otherwise take every byte.
  int unsigned stall_left = 0;
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      code_ch.ready <= 1'b0;
    end else if (idling && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(1, 19) - 1;
      code_ch.ready <= 1'b0;
    end else begin
      code_ch.ready <= 1'b1;
    end
  end

  // Check every result transfer against the oldest owed byte.
  always @(posedge clk) begin
    if (!rst && code_ch.valid && code_ch.ready) sb.check(code_ch.payload);
  end

  // Present one operation and hold it until the transfer; valid stays high
  // afterwards, and the next send or drain sets it anew.
  task send(input op_t op, input logic [31:0] operand);
    in_item_t it;
    if (idling && $urandom_range(0, 5) == 0) begin
      op_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    it.func = op;
    it.operand = operand;
    op_ch.valid <= 1'b1;
    op_ch.payload <= it;
    do @(posedge clk); while (!op_ch.ready);
    sb.note(it);
  endtask

  // Drop valid and wait for every owed byte, then let the back end settle.
  task drain();
    op_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write all four registers; only called with the block idle.
  task set_regs(input logic [63:0] tape, outv, putc, getc);
    logic [63:0] v [4];
    v = '{tape, outv, putc, getc};
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= 2'(i);
      cfg_data <= v[i];
      @(posedge clk);
      sb.regs[i] = v[i];
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 3))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  // Mostly well-formed programs: loops nest and close, with the odd stray
  // close or unknown operation mixed in.
  task random_ops(input int n);
    int r;
    op_t op;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 3) op = OP_BAD;
      else if (r < 5) op = OP_CLOSE;
      else if (r < 16) op = (sb.depth < 8) ? OP_OPEN : OP_CLOSE;
      else if (r < 28) op = (sb.depth > 0) ? OP_CLOSE : OP_OPEN;
      else if (r < 31) op = OP_START;
      else if (r < 33) op = OP_FINISH;
      else op = op_t'($urandom_range(1, 13));
      send(op, rand_operand());
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: every operation, error cases and the field extremes.
    set_regs('0, '0, '0, '0);
    send(OP_CLOSE, '0);
    send(OP_BAD, 32'hFFFF_FFFF);
    send(OP_START, '0);
    send(OP_LEFT1, '0);
    send(OP_RIGHT1, '0);
    send(OP_LEFTN, 32'h0);
    send(OP_RIGHTN, 32'hFFFF_FFFF);
    send(OP_LEFTN, 32'h8000_0001);
    send(OP_ZERO, '0);
    send(OP_INC, '0);
    send(OP_DEC, '0);
    send(OP_ADDN, 32'h0000_01FF);
    send(OP_SUBN, 32'hFFFF_FF00);
    send(OP_OPEN, '0);
    send(OP_OPEN, '0);
    send(OP_PRINT, '0);
    send(OP_INPUT, '0);
    send(OP_CLOSE, '0);
    send(OP_CLOSE, '0);
    send(OP_CLOSE, '0);
    send(OP_FINISH, '0);
    send(OP_START, '0);
    send(OP_FINISH, '0);
    drain();

    set_regs('1, '1, '1, '1);
    send(OP_START, '0);
    send(OP_PRINT, '0);
    send(OP_INPUT, '0);
    random_ops(80);
    // Hold the sender until the block has emitted everything.
    drain();

    set_regs(rand64(), rand64(), rand64(), rand64());
    random_ops(60);
    idling = 1'b0;
    random_ops(40);
    drain();

    // Nest to the stack limit, overflow once, then unwind a few loops.
    set_regs(64'h0123_4567_89AB_CDEF, rand64(), rand64(), 64'h8000_0000_0000_0001);
    while (sb.depth < STACK_LIMIT) send(OP_OPEN, $urandom());
    send(OP_OPEN, '0);
    repeat (16) send(OP_CLOSE, $urandom());
    send(OP_OPEN, '0);
    send(OP_CLOSE, '0);
    drain();

    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
